>>> rtl/mrfp_pkg.sv
// Shared constants, types and the code length table of the motor reply frame parser.
`timescale 1ns / 1ps

package mrfp_pkg;

    localparam int RX_BUFFER_DEPTH = 8;
    localparam int BUF_IDX_W       = $clog2(RX_BUFFER_DEPTH);
    localparam int CNT_W           = $clog2(RX_BUFFER_DEPTH + 1);
    localparam int LEN_W           = 3;
    localparam int USED_BYTES      = 5;

    localparam int ADDR_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ADDR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_ADDR = 1'b1;

    localparam logic [ADDR_W-1:0] FIRST_ADDR_RESET  = 8'h01;
    localparam logic [ADDR_W-1:0] SECOND_ADDR_RESET = 8'h02;

    localparam logic [7:0] FC_ENCODER    = 8'h31;
    localparam logic [7:0] FC_SPEED      = 8'h35;
    localparam logic [7:0] FC_POSITION   = 8'h36;
    localparam logic [7:0] FC_POS_ERROR  = 8'h37;
    localparam logic [7:0] FC_MOTOR      = 8'h3A;
    localparam logic [7:0] FC_HOME       = 8'h3B;
    localparam logic [7:0] FC_HOME_MOTOR = 8'h3C;

    localparam logic [7:0] SIGN_POSITIVE = 8'h00;

    localparam logic [LEN_W-1:0] LEN_WORD  = 3'd6;
    localparam logic [LEN_W-1:0] LEN_SPEED = 3'd4;
    localparam logic [LEN_W-1:0] LEN_PAIR  = 3'd3;
    localparam logic [LEN_W-1:0] LEN_ACK   = 3'd2;

    localparam logic AXIS_FIRST  = 1'b0;
    localparam logic AXIS_SECOND = 1'b1;

    typedef enum logic [2:0] {
        PH_ADDR = 3'b001,
        PH_CODE = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    typedef struct packed {
        logic                       done;
        logic                       axis;
        logic [7:0]                 code;
        logic [USED_BYTES-1:0][7:0] data;
    } frame_t;

    typedef struct packed {
        logic [31:0] position;
        logic [15:0] speed;
        logic [15:0] encoder;
        logic [31:0] pos_error;
        logic [7:0]  motor_flags;
        logic [7:0]  home_flags;
        logic [7:0]  last_ack;
    } rec_t;

    function automatic logic [LEN_W-1:0] length_for_code(input logic [7:0] code);
        logic [LEN_W-1:0] len;
        case (code)
            FC_POSITION, FC_POS_ERROR: len = LEN_WORD;
            FC_SPEED:                  len = LEN_SPEED;
            FC_ENCODER, FC_HOME_MOTOR: len = LEN_PAIR;
            default:                   len = LEN_ACK;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/mrfp_parser.sv
// Byte parser: address match, function code and data byte collection.
`timescale 1ns / 1ps

module mrfp_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mrfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mrfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           accept,
    input  logic [7:0]                     rx_byte,
    output logic                           last_pending,
    output mrfp_pkg::frame_t               frame
);
    import mrfp_pkg::*;

    logic [ADDR_W-1:0] first_addr_reg;
    logic [ADDR_W-1:0] second_addr_reg;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic              axis_reg;
    logic              axis_next;
    logic [7:0]        code_reg;
    logic [7:0]        code_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [LEN_W-1:0]  expected_reg;
    logic [LEN_W-1:0]  expected_next;
    logic [7:0]        buf_reg [RX_BUFFER_DEPTH];
    logic              room;
    logic [CNT_W-1:0]  count_inc;
    logic              buf_we;

    assign room      = count_reg < CNT_W'(RX_BUFFER_DEPTH);
    assign count_inc = room ? count_reg + CNT_W'(1) : count_reg;
    assign last_pending = (phase_reg == PH_DATA) && (count_inc >= CNT_W'(expected_reg));
    assign buf_we    = accept && (phase_reg == PH_DATA) && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_addr_reg  <= FIRST_ADDR_RESET;
            second_addr_reg <= SECOND_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_ADDR:  first_addr_reg  <= cfg_wdata[ADDR_W-1:0];
                REG_SECOND_ADDR: second_addr_reg <= cfg_wdata[ADDR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        axis_next     = axis_reg;
        code_next     = code_reg;
        count_next    = count_reg;
        expected_next = expected_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_ADDR:
                begin
                    if (rx_byte == first_addr_reg)
                    begin
                        axis_next  = AXIS_FIRST;
                        phase_next = PH_CODE;
                    end
                    else if (rx_byte == second_addr_reg)
                    begin
                        axis_next  = AXIS_SECOND;
                        phase_next = PH_CODE;
                    end
                end
                PH_CODE:
                begin
                    code_next     = rx_byte;
                    count_next    = '0;
                    expected_next = length_for_code(rx_byte);
                    phase_next    = PH_DATA;
                end
                PH_DATA:
                begin
                    count_next = count_inc;
                    if (last_pending)
                    begin
                        phase_next = PH_ADDR;
                    end
                end
                default:
                begin
                    phase_next = PH_ADDR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ADDR;
            axis_reg     <= AXIS_FIRST;
            code_reg     <= '0;
            count_reg    <= '0;
            expected_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            axis_reg     <= axis_next;
            code_reg     <= code_next;
            count_reg    <= count_next;
            expected_reg <= expected_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_reg[count_reg[BUF_IDX_W-1:0]] <= rx_byte;
        end
    end

    // The completing byte is always the check byte, so only stored bytes feed the record.
    always_comb
    begin
        frame.done = accept && last_pending;
        frame.axis = axis_reg;
        frame.code = code_reg;
        for (int i = 0; i < USED_BYTES; i++)
        begin
            frame.data[i] = buf_reg[i];
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_reg))
        else $error("Parser phase is not one-hot.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (count_reg < CNT_W'(expected_reg)))
        else $error("Data count reached the frame length without completing.");
    assert property (@(posedge clk) disable iff (!rst_n)
        frame.done |=> (phase_reg == PH_ADDR))
        else $error("Parser did not return to address search after a frame.");
`endif

endmodule

>>> rtl/mrfp_records.sv
// Per-axis status records and their update from a completed frame.
`timescale 1ns / 1ps

module mrfp_records (
    input  logic             clk,
    input  logic             rst_n,
    input  mrfp_pkg::frame_t frame,
    output mrfp_pkg::rec_t   upd
);
    import mrfp_pkg::*;

    rec_t        rec_reg [2];
    rec_t        cur;
    logic [31:0] word_mag;
    logic [15:0] half_mag;

    assign cur      = rec_reg[frame.axis];
    assign word_mag = {frame.data[1], frame.data[2], frame.data[3], frame.data[4]};
    assign half_mag = {frame.data[1], frame.data[2]};

    always_comb
    begin
        upd = cur;
        case (frame.code)
            FC_POSITION:
                upd.position = (frame.data[0] == SIGN_POSITIVE) ? word_mag : -word_mag;
            FC_POS_ERROR:
                upd.pos_error = (frame.data[0] == SIGN_POSITIVE) ? word_mag : -word_mag;
            FC_SPEED:
                upd.speed = (frame.data[0] == SIGN_POSITIVE) ? half_mag : -half_mag;
            FC_ENCODER:
                upd.encoder = {frame.data[0], frame.data[1]};
            FC_MOTOR:
                upd.motor_flags = frame.data[0];
            FC_HOME:
                upd.home_flags = frame.data[0];
            FC_HOME_MOTOR:
            begin
                upd.home_flags  = frame.data[0];
                upd.motor_flags = frame.data[1];
            end
            default:
                upd.last_ack = frame.data[0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg[0] <= '0;
            rec_reg[1] <= '0;
        end
        else if (frame.done)
        begin
            rec_reg[frame.axis] <= upd;
        end
    end

endmodule

>>> rtl/motor_reply_frame_parser_unit.sv
// Top level of the motor reply frame parser: handshakes and the result register.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  rx_byte
//   out      output     out_valid/out_ready  axis, func_code, position, speed, encoder_value,
//                                            position_error, motor_flags, home_flags, last_ack
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// One byte is taken per cycle; a completed reply appears on the output in the cycle after
// its last byte. The result register decouples the two sides: bytes keep flowing while a
// record waits, and only the byte that would complete the next reply is held off until the
// waiting record is taken. Reset clears the parser and both records, resets the addresses.
`timescale 1ns / 1ps

module motor_reply_frame_parser_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mrfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            axis,
    output logic [7:0]                      func_code,
    output logic signed [31:0]              position,
    output logic signed [15:0]              speed,
    output logic [15:0]                     encoder_value,
    output logic signed [31:0]              position_error,
    output logic [7:0]                      motor_flags,
    output logic [7:0]                      home_flags,
    output logic [7:0]                      last_ack
);
    import mrfp_pkg::*;

    logic       accept;
    logic       last_pending;
    frame_t     frame;
    rec_t       upd;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       axis_reg;
    logic [7:0] code_reg;
    rec_t       rec_out_reg;

    assign in_ready = !out_valid_reg || out_ready || !last_pending;
    assign accept   = in_valid && in_ready;

    mrfp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .last_pending (last_pending),
        .frame        (frame)
    );

    mrfp_records u_records (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame),
        .upd   (upd)
    );

    always_comb
    begin
        if (frame.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.done)
        begin
            axis_reg    <= frame.axis;
            code_reg    <= frame.code;
            rec_out_reg <= upd;
        end
    end

    assign out_valid      = out_valid_reg;
    assign axis           = axis_reg;
    assign func_code      = code_reg;
    assign position       = $signed(rec_out_reg.position);
    assign speed          = $signed(rec_out_reg.speed);
    assign encoder_value  = rec_out_reg.encoder;
    assign position_error = $signed(rec_out_reg.pos_error);
    assign motor_flags    = rec_out_reg.motor_flags;
    assign home_flags     = rec_out_reg.home_flags;
    assign last_ack       = rec_out_reg.last_ack;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        frame.done |-> (!out_valid_reg || out_ready))
        else $error("A completed reply would overwrite a record not yet taken.");
    assert property (@(posedge clk) disable iff (!rst_n)
        frame.done |=> (out_valid && (axis == $past(frame.axis))))
        else $error("Completed reply was not presented for its axis.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && !frame.done) |=> out_valid_reg)
        else $error("Waiting record was dropped before its beat completed.");
`endif

endmodule

>>> bench/tb_motor_reply_frame_parser_unit.sv
// Self-checking testbench for the motor reply frame parser, with a byte driver and a reply monitor.
`timescale 1ns / 1ps

module tb_motor_reply_frame_parser_unit;

    import mrfp_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int RUN_LIMIT_NS = 5_000_000;

    localparam logic [25*8-1:0] OPENING = {
        8'h00,
        FIRST_ADDR_RESET, FC_SPEED, 8'hFF, 8'h00, 8'h01, 8'hC3,
        SECOND_ADDR_RESET, FC_ENCODER, 8'hFF, 8'hFF, 8'h5A,
        FIRST_ADDR_RESET, FC_HOME_MOTOR, 8'hAA, 8'h55, 8'h00,
        SECOND_ADDR_RESET, FC_POS_ERROR, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00, 8'hFF
    };

    typedef struct packed {
        logic       axis;
        logic [7:0] code;
        rec_t       rec;
    } reply_t;

    typedef struct {
        logic [7:0] value;
        bit         drain;
    } rx_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            rx_byte = 8'h00;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  axis;
    logic [7:0]            func_code;
    logic signed [31:0]    position;
    logic signed [15:0]    speed;
    logic [15:0]           encoder_value;
    logic signed [31:0]    position_error;
    logic [7:0]            motor_flags;
    logic [7:0]            home_flags;
    logic [7:0]            last_ack;

    rx_item_t byte_queue[$];
    reply_t   pending_replies[$];
    rx_item_t tx_next;
    reply_t   seen_reply;
    reply_t   due_reply;

    int tx_gap = 0;
    bit tx_burst = 1'b0;
    int ready_idle = 0;
    bit rx_burst = 1'b0;
    int hold_asks = 0;
    int hold_seen = 0;

    int mismatch_count = 0;
    int reply_count = 0;
    int second_axis_replies = 0;
    int bytes_accepted = 0;
    int settings_used = 1;

    phase_t     mdl_phase;
    logic       mdl_axis;
    logic [7:0] mdl_code;
    logic [7:0] mdl_buf [RX_BUFFER_DEPTH];
    logic [3:0] mdl_count;
    logic [2:0] mdl_need;
    rec_t       mdl_rec [2];
    logic [7:0] mdl_addr [2];

    motor_reply_frame_parser_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .axis           (axis),
        .func_code      (func_code),
        .position       (position),
        .speed          (speed),
        .encoder_value  (encoder_value),
        .position_error (position_error),
        .motor_flags    (motor_flags),
        .home_flags     (home_flags),
        .last_ack       (last_ack)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [2:0] reply_length(input logic [7:0] code);
        case (code)
            FC_POSITION, FC_POS_ERROR: return LEN_WORD;
            FC_SPEED:                  return LEN_SPEED;
            FC_ENCODER, FC_HOME_MOTOR: return LEN_PAIR;
            default:                   return LEN_ACK;
        endcase
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic reset_records();
        mdl_phase = PH_ADDR;
        mdl_axis  = AXIS_FIRST;
        mdl_code  = 8'h00;
        mdl_count = '0;
        mdl_need  = '0;
        for (int i = 0; i < RX_BUFFER_DEPTH; i++)
        begin
            mdl_buf[i] = 8'h00;
        end
        mdl_rec[0]  = '0;
        mdl_rec[1]  = '0;
        mdl_addr[0] = FIRST_ADDR_RESET;
        mdl_addr[1] = SECOND_ADDR_RESET;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [31:0] word;
        logic [15:0] half;
        logic        a;
        reply_t      r;
        case (mdl_phase)
            PH_ADDR:
            begin
                if (b == mdl_addr[0])
                begin
                    mdl_axis  = AXIS_FIRST;
                    mdl_phase = PH_CODE;
                end
                else if (b == mdl_addr[1])
                begin
                    mdl_axis  = AXIS_SECOND;
                    mdl_phase = PH_CODE;
                end
            end
            PH_CODE:
            begin
                mdl_code  = b;
                mdl_count = '0;
                mdl_need  = reply_length(b);
                mdl_phase = PH_DATA;
            end
            PH_DATA:
            begin
                if (int'(mdl_count) < RX_BUFFER_DEPTH)
                begin
                    mdl_buf[mdl_count[2:0]] = b;
                    mdl_count = mdl_count + 4'd1;
                end
                if (mdl_count >= {1'b0, mdl_need})
                begin
                    a = mdl_axis;
                    word = {mdl_buf[1], mdl_buf[2], mdl_buf[3], mdl_buf[4]};
                    half = {mdl_buf[1], mdl_buf[2]};
                    if (mdl_buf[0] != SIGN_POSITIVE)
                    begin
                        word = -word;
                        half = -half;
                    end
                    case (mdl_code)
                        FC_POSITION:  mdl_rec[a].position    = word;
                        FC_POS_ERROR: mdl_rec[a].pos_error   = word;
                        FC_SPEED:     mdl_rec[a].speed       = half;
                        FC_ENCODER:   mdl_rec[a].encoder     = {mdl_buf[0], mdl_buf[1]};
                        FC_MOTOR:     mdl_rec[a].motor_flags = mdl_buf[0];
                        FC_HOME:      mdl_rec[a].home_flags  = mdl_buf[0];
                        FC_HOME_MOTOR:
                        begin
                            mdl_rec[a].home_flags  = mdl_buf[0];
                            mdl_rec[a].motor_flags = mdl_buf[1];
                        end
                        default:      mdl_rec[a].last_ack    = mdl_buf[0];
                    endcase
                    mdl_phase = PH_ADDR;
                    r.axis = a;
                    r.code = mdl_code;
                    r.rec  = mdl_rec[a];
                    pending_replies.push_back(r);
                end
            end
            default: mdl_phase = PH_ADDR;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: reply %0d, %s: expected 0x%0h, got 0x%0h",
                 $time, reply_count, what, want, got);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            report_mismatch(what, want, got);
        end
    endtask

    // Driver: holds each byte until it is taken, then idles for a random gap; a drain byte waits until no reply is due.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
            tx_gap   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (tx_gap > 0)
            begin
                in_valid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end
            else if (byte_queue.size() > 0 &&
                     !(byte_queue[0].drain && pending_replies.size() > 0))
            begin
                tx_next = byte_queue.pop_front();
                in_valid <= 1'b1;
                rx_byte  <= tx_next.value;
                tx_gap   <= tx_burst ? 0 : idle_length();
                if ($urandom_range(0, 47) == 0)
                begin
                    tx_burst <= !tx_burst;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_idle <= 0;
        end
        else if (hold_asks != hold_seen)
        begin
            hold_seen  <= hold_asks;
            ready_idle <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end
        else if (ready_idle > 0)
        begin
            ready_idle <= ready_idle - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
            begin
                rx_burst <= !rx_burst;
            end
            if (!rx_burst && $urandom_range(0, 3) == 0)
            begin
                out_ready  <= 1'b0;
                ready_idle <= idle_length();
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: checks each reply beat, then feeds each accepted byte to the predictor.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen_reply.axis            = axis;
                seen_reply.code            = func_code;
                seen_reply.rec.position    = position;
                seen_reply.rec.speed       = speed;
                seen_reply.rec.encoder     = encoder_value;
                seen_reply.rec.pos_error   = position_error;
                seen_reply.rec.motor_flags = motor_flags;
                seen_reply.rec.home_flags  = home_flags;
                seen_reply.rec.last_ack    = last_ack;
                if (pending_replies.size() == 0)
                begin
                    report_mismatch("reply with none due, func_code", '0, 32'(func_code));
                end
                else
                begin
                    due_reply = pending_replies.pop_front();
                    if (due_reply.axis == AXIS_SECOND)
                    begin
                        second_axis_replies++;
                    end
                    check_field("axis", 32'(due_reply.axis), 32'(seen_reply.axis));
                    check_field("func_code", 32'(due_reply.code), 32'(seen_reply.code));
                    check_field("position", due_reply.rec.position, seen_reply.rec.position);
                    check_field("speed", 32'(due_reply.rec.speed), 32'(seen_reply.rec.speed));
                    check_field("encoder_value", 32'(due_reply.rec.encoder),
                                32'(seen_reply.rec.encoder));
                    check_field("position_error", due_reply.rec.pos_error,
                                seen_reply.rec.pos_error);
                    check_field("motor_flags", 32'(due_reply.rec.motor_flags),
                                32'(seen_reply.rec.motor_flags));
                    check_field("home_flags", 32'(due_reply.rec.home_flags),
                                32'(seen_reply.rec.home_flags));
                    check_field("last_ack", 32'(due_reply.rec.last_ack),
                                32'(seen_reply.rec.last_ack));
                end
                reply_count++;
            end
            if (in_valid && in_ready)
            begin
                bytes_accepted++;
                parse_rx_byte(rx_byte);
            end
        end
    end

    task automatic push_byte(input logic [7:0] value, input bit drain);
        rx_item_t item;
        item.value = value;
        item.drain = drain;
        byte_queue.push_back(item);
    endtask

    task automatic queue_frame(inout int sent);
        logic [7:0] code;
        logic [7:0] b;
        int         len;
        if ($urandom_range(0, 99) < 10)
        begin
            repeat ($urandom_range(1, 3))
            begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        push_byte(mdl_addr[1'($urandom_range(0, 1))], $urandom_range(0, 29) == 0);
        case ($urandom_range(0, 9))
            0:       code = FC_POSITION;
            1:       code = FC_POS_ERROR;
            2:       code = FC_SPEED;
            3:       code = FC_ENCODER;
            4:       code = FC_MOTOR;
            5:       code = FC_HOME;
            6:       code = FC_HOME_MOTOR;
            default: code = 8'($urandom_range(0, 255));
        endcase
        push_byte(code, 1'b0);
        len = int'(reply_length(code));
        if ($urandom_range(0, 19) == 0)
        begin
            len = int'($urandom_range(0, len - 1));
        end
        for (int i = 0; i < len; i++)
        begin
            if (i == 0 && (code == FC_POSITION || code == FC_POS_ERROR || code == FC_SPEED))
            begin
                b = $urandom_range(0, 1) ? SIGN_POSITIVE : 8'($urandom_range(1, 255));
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
            end
            push_byte(b, 1'b0);
        end
        sent = sent + len + 2;
    endtask

    task automatic wait_quiet();
        while (byte_queue.size() != 0 || in_valid || pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        mdl_addr[idx] = value;
    endtask

    initial
    begin
        logic [7:0] first_addr;
        logic [7:0] second_addr;
        int         sent;
        reset_records();
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        for (int i = 0; i < 25; i++)
        begin
            push_byte(OPENING[(24 - i) * 8 +: 8], i == 12);
        end
        wait_quiet();

        for (int setting = 0; setting < 6; setting++)
        begin
            case (setting)
                0:
                begin
                    first_addr  = 8'h00;
                    second_addr = 8'hFF;
                end
                1:
                begin
                    first_addr  = 8'hFF;
                    second_addr = 8'h00;
                end
                2:
                begin
                    first_addr  = 8'h5A;
                    second_addr = 8'h5A;
                end
                3:
                begin
                    first_addr  = FC_POSITION;
                    second_addr = FC_HOME_MOTOR;
                end
                default:
                begin
                    first_addr  = 8'($urandom_range(0, 255));
                    second_addr = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(REG_FIRST_ADDR, first_addr);
            write_reg(REG_SECOND_ADDR, second_addr);
            settings_used++;
            if (setting == 1)
            begin
                hold_asks++;
            end
            sent = 0;
            while (sent < 85)
            begin
                queue_frame(sent);
            end
            wait_quiet();
        end

        $display("Run covered %0d bytes under %0d address settings, with every reply code.",
                 bytes_accepted, settings_used);
        $display("Checked %0d reply records, %0d of them from the second axis.",
                 reply_count, second_axis_replies);
        if (mismatch_count == 0)
        begin
            $display("[motor_reply_frame_parser_unit] OK");
        end
        else
        begin
            $display("[motor_reply_frame_parser_unit] ERROR");
        end
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Run stopped after %0d ns with %0d replies outstanding.",
                 RUN_LIMIT_NS, pending_replies.size());
        $display("[motor_reply_frame_parser_unit] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mrfp_pkg.sv
rtl/mrfp_parser.sv
rtl/mrfp_records.sv
rtl/motor_reply_frame_parser_unit.sv
bench/tb_motor_reply_frame_parser_unit.sv
